// ===== design/vlfd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the varint length frame deframer: widths, codes, item types.
// No dependencies; every other design file imports it.
package vlfd_pkg;

    localparam int MAX_HEADER_BYTES = 5;
    localparam int LENGTH_WIDTH     = 22;
    localparam int ACC_WIDTH        = 32;
    localparam int TICK_WIDTH       = 32;
    localparam int DIGIT_BITS       = 7;
    localparam int HDR_CNT_WIDTH    = $clog2(MAX_HEADER_BYTES + 1);
    localparam int CFG_INDEX_WIDTH  = 1;
    localparam int CFG_DATA_WIDTH   = 32;

    localparam logic [LENGTH_WIDTH-1:0] MAX_LEN_RESET = LENGTH_WIDTH'(32'd2097152);
    localparam logic [TICK_WIDTH-1:0]   TIMEOUT_RESET = TICK_WIDTH'(32'd30000);

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_FRAME_LENGTH = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TIMEOUT_TICKS    = CFG_INDEX_WIDTH'(1);

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_BODY   = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_TOO_LONG = 2'd1,
        ERR_INVALID  = 2'd2,
        ERR_TIMEOUT  = 2'd3
    } err_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        kind_t                   item_kind;
        logic [7:0]              body_byte;
        logic [LENGTH_WIDTH-1:0] frame_length;
        logic                    first_of_frame;
        logic                    last_of_frame;
        err_t                    err_code;
    } out_item_t;

    typedef struct packed {
        logic     valid;
        in_item_t item;
    } in_slot_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } res_slot_t;

endpackage

// ===== design/vlfd_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the deframer: byte/tick input, frame items out.
// Depends on vlfd_pkg.
interface vlfd_in_if import vlfd_pkg::*;;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] data_byte;

    modport source (output valid, output mode, output data_byte, input ready);
    modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface vlfd_out_if import vlfd_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [1:0]              item_kind;
    logic [7:0]              body_byte;
    logic [LENGTH_WIDTH-1:0] frame_length;
    logic                    first_of_frame;
    logic                    last_of_frame;
    logic [1:0]              err_code;

    modport source (output valid, output item_kind, output body_byte, output frame_length,
                    output first_of_frame, output last_of_frame, output err_code,
                    input ready);
    modport sink   (input valid, input item_kind, input body_byte, input frame_length,
                    input first_of_frame, input last_of_frame, input err_code,
                    output ready);
endinterface

// ===== design/vlfd_in_stage.sv =====
`timescale 1ns / 1ps
// Input register of the deframer: holds one accepted item until the core takes it.
// Depends on vlfd_pkg and vlfd_in_if.
module vlfd_in_stage import vlfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    vlfd_in_if.sink   stream,
    input  logic      take,
    output in_slot_t  slot
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     load;

    assign stream.ready = !valid_reg || take;
    assign load         = stream.valid && stream.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.mode      <= stream.mode;
            item_reg.data_byte <= stream.data_byte;
        end
    end

    assign slot.valid = valid_reg;
    assign slot.item  = item_reg;

endmodule

// ===== design/vlfd_core.sv =====
`timescale 1ns / 1ps
// Frame state and per-item decode: length header, body marks, tick timeout, dead link.
// Holds the configuration registers. Depends on vlfd_pkg.
module vlfd_core import vlfd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0] wr_index,
    input  logic [CFG_DATA_WIDTH-1:0]  wr_data,
    input  in_slot_t                   slot,
    input  logic                       out_free,
    output logic                       take,
    output res_slot_t                  res
);

    logic [LENGTH_WIDTH-1:0]  max_len_reg;
    logic [TICK_WIDTH-1:0]    timeout_reg;

    logic [ACC_WIDTH-1:0]     acc_reg,      acc_next;
    logic [HDR_CNT_WIDTH-1:0] hdr_cnt_reg,  hdr_cnt_next;
    logic                     in_body_reg,  in_body_next;
    logic [LENGTH_WIDTH-1:0]  cur_len_reg,  cur_len_next;
    logic [LENGTH_WIDTH-1:0]  left_reg,     left_next;
    logic                     dead_reg,     dead_next;
    logic [TICK_WIDTH-1:0]    tick_reg,     tick_next;

    logic [ACC_WIDTH-1:0]     digit_shifted;
    logic [ACC_WIDTH-1:0]     acc_merged;
    logic [HDR_CNT_WIDTH-1:0] hdr_cnt_inc;
    logic [TICK_WIDTH-1:0]    tick_inc;
    logic [LENGTH_WIDTH-1:0]  left_dec;
    logic                     has_res;
    out_item_t                item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_MAX_FRAME_LENGTH: max_len_reg <= wr_data[LENGTH_WIDTH-1:0];
                CFG_TIMEOUT_TICKS:    timeout_reg <= wr_data[TICK_WIDTH-1:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        digit_shifted = '0;
        for (int k = 0; k < MAX_HEADER_BYTES; k++)
        begin
            if ((DIGIT_BITS * k) < ACC_WIDTH && hdr_cnt_reg == HDR_CNT_WIDTH'(k))
            begin
                digit_shifted = ACC_WIDTH'(ACC_WIDTH'(slot.item.data_byte[DIGIT_BITS-1:0])
                                << (DIGIT_BITS * k));
            end
        end
    end

    assign acc_merged  = acc_reg | digit_shifted;
    assign hdr_cnt_inc = hdr_cnt_reg + HDR_CNT_WIDTH'(1);
    assign tick_inc    = (tick_reg == '1) ? tick_reg : tick_reg + TICK_WIDTH'(1);
    assign left_dec    = left_reg - LENGTH_WIDTH'(1);

    always_comb
    begin
        acc_next     = acc_reg;
        hdr_cnt_next = hdr_cnt_reg;
        in_body_next = in_body_reg;
        cur_len_next = cur_len_reg;
        left_next    = left_reg;
        dead_next    = dead_reg;
        tick_next    = tick_reg;
        has_res      = 1'b0;
        item         = '0;

        if (!dead_reg)
        begin
            if (slot.item.mode == MODE_TICK)
            begin
                tick_next = tick_inc;
                if (tick_inc >= timeout_reg)
                begin
                    has_res        = 1'b1;
                    item.item_kind = KIND_ERROR;
                    item.err_code  = ERR_TIMEOUT;
                    dead_next      = 1'b1;
                end
            end
            else if (!in_body_reg)
            begin
                has_res = 1'b1;
                if (slot.item.data_byte[7])
                begin
                    if (hdr_cnt_inc >= HDR_CNT_WIDTH'(MAX_HEADER_BYTES))
                    begin
                        item.item_kind = KIND_ERROR;
                        item.err_code  = ERR_INVALID;
                        dead_next      = 1'b1;
                    end
                    else
                    begin
                        item.item_kind = KIND_HEADER;
                        acc_next       = acc_merged;
                        hdr_cnt_next   = hdr_cnt_inc;
                    end
                end
                else if (acc_merged == '0 || acc_merged[ACC_WIDTH-1])
                begin
                    item.item_kind = KIND_ERROR;
                    item.err_code  = ERR_INVALID;
                    dead_next      = 1'b1;
                end
                else if (acc_merged > ACC_WIDTH'(max_len_reg))
                begin
                    item.item_kind = KIND_ERROR;
                    item.err_code  = ERR_TOO_LONG;
                    dead_next      = 1'b1;
                end
                else
                begin
                    item.item_kind    = KIND_HEADER;
                    item.frame_length = acc_merged[LENGTH_WIDTH-1:0];
                    cur_len_next      = acc_merged[LENGTH_WIDTH-1:0];
                    left_next         = acc_merged[LENGTH_WIDTH-1:0];
                    in_body_next      = 1'b1;
                    acc_next          = '0;
                    hdr_cnt_next      = '0;
                end
            end
            else
            begin
                has_res             = 1'b1;
                item.item_kind      = KIND_BODY;
                item.body_byte      = slot.item.data_byte;
                item.frame_length   = cur_len_reg;
                item.first_of_frame = (left_reg == cur_len_reg);
                left_next           = left_dec;
                if (left_dec == '0)
                begin
                    item.last_of_frame = 1'b1;
                    in_body_next       = 1'b0;
                    cur_len_next       = '0;
                    tick_next          = '0;
                end
            end
        end
    end

    assign take      = slot.valid && (!has_res || out_free);
    assign res.valid = take && has_res;
    assign res.item  = item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            hdr_cnt_reg <= '0;
            in_body_reg <= 1'b0;
            cur_len_reg <= '0;
            left_reg    <= '0;
            dead_reg    <= 1'b0;
            tick_reg    <= '0;
        end
        else if (take)
        begin
            acc_reg     <= acc_next;
            hdr_cnt_reg <= hdr_cnt_next;
            in_body_reg <= in_body_next;
            cur_len_reg <= cur_len_next;
            left_reg    <= left_next;
            dead_reg    <= dead_next;
            tick_reg    <= tick_next;
        end
    end

    a_dead_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        dead_reg |=> dead_reg)
        else $error("dead link came back");

    a_error_kills: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.item.item_kind == KIND_ERROR) |=> dead_reg)
        else $error("error report without dead link");

    a_body_left: assert property (@(posedge clk) disable iff (!rst_n)
        in_body_reg |-> (left_reg != '0 && left_reg <= cur_len_reg))
        else $error("body count out of range");

    a_hdr_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_cnt_reg < HDR_CNT_WIDTH'(MAX_HEADER_BYTES))
        else $error("header byte count overrun");

    a_no_res_dead: assert property (@(posedge clk) disable iff (!rst_n)
        dead_reg |-> !res.valid)
        else $error("result from dead link");

endmodule

// ===== design/vlfd_out_stage.sv =====
`timescale 1ns / 1ps
// Result register of the deframer: holds one item until the sink takes it.
// Depends on vlfd_pkg and vlfd_out_if.
module vlfd_out_stage import vlfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  res_slot_t   res,
    output logic        out_free,
    vlfd_out_if.source  frames
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    assign out_free = !valid_reg || frames.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (res.valid)
        begin
            valid_next = 1'b1;
        end
        else if (frames.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            item_reg <= res.item;
        end
    end

    assign frames.valid          = valid_reg;
    assign frames.item_kind      = item_reg.item_kind;
    assign frames.body_byte      = item_reg.body_byte;
    assign frames.frame_length   = item_reg.frame_length;
    assign frames.first_of_frame = item_reg.first_of_frame;
    assign frames.last_of_frame  = item_reg.last_of_frame;
    assign frames.err_code       = item_reg.err_code;

endmodule

// ===== design/varint_length_frame_deframer.sv =====
`timescale 1ns / 1ps
// Top level of the varint length frame deframer.
// Depends on vlfd_pkg, vlfd_if, vlfd_in_stage, vlfd_core, vlfd_out_stage.
//
//   port     | dir  | kind        | payload
//   stream   | in   | valid/ready | mode, data_byte
//   frames   | out  | valid/ready | item_kind, body_byte, frame_length, first/last, err_code
//   wr_*     | in   | write only  | wr_index, wr_data
//
// One item per cycle sustained while the sink keeps up; an item passes the input register, then the result register.
// The frame state updates in one pass through the core between those two registers.
// Reset is asynchronous, active low; configuration returns to 2097152 bytes, 30000 ticks.
// A stalled sink holds the result register; the input register still takes one item,
// and items that give no result keep flowing while a result waits.
module varint_length_frame_deframer import vlfd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    vlfd_in_if.sink                    stream,
    vlfd_out_if.source                 frames,
    input  logic                       wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0] wr_index,
    input  logic [CFG_DATA_WIDTH-1:0]  wr_data
);

    in_slot_t  slot;
    res_slot_t res;
    logic      take;
    logic      out_free;

    vlfd_in_stage u_in_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream),
        .take   (take),
        .slot   (slot)
    );

    vlfd_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .slot     (slot),
        .out_free (out_free),
        .take     (take),
        .res      (res)
    );

    vlfd_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .res      (res),
        .out_free (out_free),
        .frames   (frames)
    );

endmodule
